/* rtl/scba_pkg.sv */
// Shared types, constants and size-class table of the size-class block allocator.
package scba_pkg;

    localparam int unsigned HEAP_BYTES  = 65536;
    localparam int unsigned NUM_CLASSES = 18;
    localparam int unsigned STORE_DEPTH = HEAP_BYTES / 8;
    localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
    localparam int unsigned CLASS_W     = 5;
    localparam int unsigned CNT_W       = 14;
    localparam int unsigned SIZE_W      = 29;

    localparam logic [CNT_W-1:0]  COUNT_MAX = 14'd16383;
    localparam logic [SIZE_W-1:0] MAX_SIZE  = 29'd268435456;
    localparam logic [31:0]       HEAP_TOP  = 32'hFFFF_FFF8;
    localparam logic [3:0]        MIN_ALIGN = 4'd3;

    // command kinds on the input channel
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_SIZE = 2'd1;
    localparam logic [1:0] STAT_NO_SPACE = 2'd2;
    localparam logic [1:0] STAT_FOREIGN  = 2'd3;

    // work kinds queued between front and back
    localparam logic [1:0] OP_DONE  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [1:0]         status;
        logic [CLASS_W-1:0] cls;
        logic [3:0]         alg;
        logic [IDX_W-1:0]   idx;
    } scba_item_t;

    typedef struct packed {
        logic [31:0] base_al;
        logic [31:0] limit;
    } scba_heap_t;

    typedef struct packed {
        logic [31:0]        data_addr;
        logic [1:0]         status;
        logic [CLASS_W-1:0] cls;
        logic               reused;
    } scba_result_t;

    function automatic logic [SIZE_W-1:0] class_bytes(input logic [CLASS_W-1:0] c);
        logic [SIZE_W-1:0] b;
        case (c)
            5'd0:    b = 29'd8;
            5'd1:    b = 29'd1 << 4;
            5'd2:    b = 29'd24;
            5'd3:    b = 29'd1 << 5;
            5'd4:    b = 29'd1 << 6;
            5'd5:    b = 29'd1 << 7;
            5'd6:    b = 29'd1 << 8;
            5'd7:    b = 29'd1 << 9;
            5'd8:    b = 29'd1 << 10;
            5'd9:    b = 29'd1 << 11;
            5'd10:   b = 29'd1 << 12;
            5'd11:   b = 29'd1 << 13;
            5'd12:   b = 29'd1 << 15;
            5'd13:   b = 29'd1 << 16;
            5'd14:   b = 29'd1 << 18;
            5'd15:   b = 29'd1 << 20;
            5'd16:   b = 29'd1 << 23;
            default: b = 29'd1 << 28;
        endcase
        return b;
    endfunction

    // first class whose size covers the request, largest class otherwise
    function automatic logic [CLASS_W-1:0] class_of(input logic [SIZE_W-1:0] size);
        logic [CLASS_W-1:0] c;
        c = CLASS_W'(NUM_CLASSES - 1);
        for (int i = NUM_CLASSES - 2; i >= 0; i--) begin
            if (size <= class_bytes(CLASS_W'(i))) begin
                c = CLASS_W'(i);
            end
        end
        return c;
    endfunction

endpackage

/* rtl/scba_front.sv */
// Front end: heap window registers and command classification.
module scba_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr,
    input  logic [31:0]                  cfg_data,
    input  logic                         cmd,
    input  logic [scba_pkg::SIZE_W-1:0]  req_size,
    input  logic [3:0]                   align_log2,
    input  logic [31:0]                  ptr_addr,
    output scba_pkg::scba_item_t         item,
    output scba_pkg::scba_heap_t         heap
);
    import scba_pkg::*;

    logic [31:0] base_al_reg;
    logic [32:0] base_p8_reg;
    logic [31:0] limit_reg;
    logic [32:0] cfg_end;
    logic [31:0] free_off;
    logic        foreign;

    assign cfg_end = {1'b0, cfg_data} + 33'(HEAP_BYTES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_al_reg <= '0;
            base_p8_reg <= 33'd8;
            limit_reg   <= 32'(HEAP_BYTES);
        end else if (cfg_wr) begin
            base_al_reg <= {cfg_data[31:3], 3'b000};
            base_p8_reg <= {1'b0, cfg_data} + 33'd8;
            limit_reg   <= (cfg_end > {1'b0, HEAP_TOP}) ? HEAP_TOP : cfg_end[31:0];
        end
    end

    assign heap.base_al = base_al_reg;
    assign heap.limit   = limit_reg;

    assign foreign  = ({1'b0, ptr_addr} < base_p8_reg) || (ptr_addr >= limit_reg);
    assign free_off = ptr_addr - base_al_reg - 32'd8;

    always_comb begin
        item.op     = OP_DONE;
        item.status = STAT_OK;
        item.cls    = '0;
        item.alg    = (align_log2 < MIN_ALIGN) ? MIN_ALIGN : align_log2;
        item.idx    = free_off[IDX_W+2:3];
        if (cmd == CMD_ALLOC) begin
            if (req_size == '0 || req_size > MAX_SIZE) begin
                item.status = STAT_BAD_SIZE;
            end else begin
                item.op  = OP_ALLOC;
                item.cls = class_of(req_size);
            end
        end else if (ptr_addr != '0) begin
            if (foreign) begin
                item.status = STAT_FOREIGN;
            end else begin
                item.op = OP_FREE;
            end
        end
    end

endmodule

/* rtl/scba_queue.sv */
// Two-entry queue of classified commands between front and back end.
module scba_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  scba_pkg::scba_item_t  wr_data,
    output logic                  rd_valid,
    input  logic                  rd_ready,
    output scba_pkg::scba_item_t  rd_data
);
    import scba_pkg::*;

    scba_item_t  slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/scba_back.sv */
// Back end: free lists, bump cursor, link and tag memories, result register.
module scba_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr,
    input  logic [31:0]           cfg_data,
    input  scba_pkg::scba_heap_t  heap,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  scba_pkg::scba_item_t  q_data,
    output logic                  res_valid,
    input  logic                  res_ready,
    output scba_pkg::scba_result_t res
);
    import scba_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_POP   = 3'd2;
    localparam logic [2:0] ST_BUMP  = 3'd3;
    localparam logic [2:0] ST_LINK0 = 3'd4;

    logic [2:0]         state_reg, state_next;
    scba_item_t         cur_reg, cur_next;
    logic [32:0]        hdr_reg, hdr_next;
    logic [31:0]        cursor_reg, cursor_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic               out_valid_reg, out_valid_next;
    scba_result_t       out_res_reg, out_res_next;

    logic [IDX_W-1:0]   list_head_reg  [NUM_CLASSES];
    logic [IDX_W-1:0]   list_tail_reg  [NUM_CLASSES];
    logic [CNT_W-1:0]   list_count_reg [NUM_CLASSES];

    logic [IDX_W-1:0]   link_mem [STORE_DEPTH];
    logic [CLASS_W-1:0] tag_mem  [STORE_DEPTH];
    logic [IDX_W-1:0]   link_rd_q;
    logic [CLASS_W-1:0] tag_rd_q;

    logic               tag_re, tag_we, link_re, link_we;
    logic [IDX_W-1:0]   tag_ra, tag_wa, link_ra, link_wa, link_wd;
    logic [CLASS_W-1:0] tag_wd;

    logic [CLASS_W-1:0] lst_wi;
    logic               head_we, tail_we, cnt_we;
    logic [IDX_W-1:0]   head_wd, tail_wd;
    logic [CNT_W-1:0]   cnt_wd;

    logic               out_free;
    logic [CLASS_W-1:0] tag_cls, sel_cls;
    logic [IDX_W-1:0]   sel_head, sel_tail, pop_idx;
    logic [CNT_W-1:0]   sel_cnt;
    logic [31:0]        pop_addr;
    logic [32:0]        mask33, hdr_calc, hdr_off;
    logic [33:0]        end_w;
    logic               no_space;
    logic [IDX_W-1:0]   bump_idx;

    assign out_free  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_res_reg;

    // a tag value beyond the class table falls into the largest class
    assign tag_cls  = (tag_rd_q >= CLASS_W'(NUM_CLASSES)) ? CLASS_W'(NUM_CLASSES - 1) : tag_rd_q;
    assign sel_cls  = (state_reg == ST_EXEC && cur_reg.op == OP_FREE) ? tag_cls : cur_reg.cls;
    assign sel_head = list_head_reg[sel_cls];
    assign sel_tail = list_tail_reg[sel_cls];
    assign sel_cnt  = list_count_reg[sel_cls];

    assign pop_idx  = (state_reg == ST_EXEC) ? sel_head : cur_reg.idx;
    assign pop_addr = heap.base_al + 32'({pop_idx, 3'b000}) + 32'd8;

    assign mask33   = (33'd1 << cur_reg.alg) - 33'd1;
    assign hdr_calc = ({1'b0, cursor_reg} + mask33) & ~mask33;
    assign end_w    = {1'b0, hdr_reg} + 34'd8 + 34'(class_bytes(cur_reg.cls));
    assign no_space = end_w > {2'b00, heap.limit};
    assign hdr_off  = hdr_reg - {1'b0, heap.base_al};
    assign bump_idx = hdr_off[IDX_W+2:3];

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        hdr_next       = hdr_reg;
        cursor_next    = cursor_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        q_ready        = 1'b0;
        tag_re         = 1'b0;
        tag_ra         = q_data.idx;
        tag_we         = 1'b0;
        tag_wa         = bump_idx;
        tag_wd         = cur_reg.cls;
        link_re        = 1'b0;
        link_ra        = sel_head;
        link_we        = 1'b0;
        link_wa        = cur_reg.idx;
        link_wd        = cur_reg.idx;
        lst_wi         = cur_reg.cls;
        head_we        = 1'b0;
        head_wd        = '0;
        tail_we        = 1'b0;
        tail_wd        = '0;
        cnt_we         = 1'b0;
        cnt_wd         = '0;

        if (out_valid_reg && res_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_ready  = 1'b1;
                    tag_re   = 1'b1;
                    cur_next = q_data;
                    if (q_data.op == OP_DONE) begin
                        out_valid_next         = 1'b1;
                        out_res_next.data_addr = '0;
                        out_res_next.status    = q_data.status;
                        out_res_next.cls       = q_data.cls;
                        out_res_next.reused    = 1'b0;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                lst_wi = sel_cls;
                if (cur_reg.op == OP_ALLOC) begin
                    if (total_reg != '0 && sel_cnt != '0) begin
                        if (sel_cnt == CNT_W'(1)) begin
                            head_we                = 1'b1;
                            tail_we                = 1'b1;
                            cnt_we                 = 1'b1;
                            cnt_wd                 = '0;
                            total_next             = total_reg - CNT_W'(1);
                            out_valid_next         = 1'b1;
                            out_res_next.data_addr = pop_addr;
                            out_res_next.status    = STAT_OK;
                            out_res_next.cls       = sel_cls;
                            out_res_next.reused    = 1'b1;
                            state_next             = ST_IDLE;
                        end else begin
                            link_re      = 1'b1;
                            cur_next.idx = sel_head;
                            state_next   = ST_POP;
                        end
                    end else begin
                        hdr_next   = hdr_calc;
                        state_next = ST_BUMP;
                    end
                end else begin
                    cur_next.cls = sel_cls;
                    if (total_reg == COUNT_MAX || sel_cnt == COUNT_MAX) begin
                        out_valid_next         = 1'b1;
                        out_res_next.data_addr = '0;
                        out_res_next.status    = STAT_OK;
                        out_res_next.cls       = sel_cls;
                        out_res_next.reused    = 1'b0;
                        state_next             = ST_IDLE;
                    end else begin
                        if (sel_cnt == '0) begin
                            head_we = 1'b1;
                            head_wd = cur_reg.idx;
                        end else begin
                            link_we = 1'b1;
                            link_wa = sel_tail;
                            link_wd = cur_reg.idx;
                        end
                        tail_we    = 1'b1;
                        tail_wd    = cur_reg.idx;
                        cnt_we     = 1'b1;
                        cnt_wd     = sel_cnt + CNT_W'(1);
                        total_next = total_reg + CNT_W'(1);
                        state_next = ST_LINK0;
                    end
                end
            end
            ST_POP: begin
                head_we                = 1'b1;
                head_wd                = link_rd_q;
                cnt_we                 = 1'b1;
                cnt_wd                 = sel_cnt - CNT_W'(1);
                total_next             = total_reg - CNT_W'(1);
                out_valid_next         = 1'b1;
                out_res_next.data_addr = pop_addr;
                out_res_next.status    = STAT_OK;
                out_res_next.cls       = cur_reg.cls;
                out_res_next.reused    = 1'b1;
                state_next             = ST_IDLE;
            end
            ST_BUMP: begin
                out_valid_next      = 1'b1;
                out_res_next.reused = 1'b0;
                if (no_space) begin
                    out_res_next.data_addr = '0;
                    out_res_next.status    = STAT_NO_SPACE;
                    out_res_next.cls       = '0;
                end else begin
                    cursor_next            = end_w[31:0];
                    tag_we                 = 1'b1;
                    out_res_next.data_addr = hdr_reg[31:0] + 32'd8;
                    out_res_next.status    = STAT_OK;
                    out_res_next.cls       = cur_reg.cls;
                end
                state_next = ST_IDLE;
            end
            ST_LINK0: begin
                link_we                = 1'b1;
                link_wa                = cur_reg.idx;
                link_wd                = '0;
                out_valid_next         = 1'b1;
                out_res_next.data_addr = '0;
                out_res_next.status    = STAT_OK;
                out_res_next.cls       = cur_reg.cls;
                out_res_next.reused    = 1'b0;
                state_next             = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cursor_reg    <= '0;
            total_reg     <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                list_head_reg[i]  <= '0;
                list_tail_reg[i]  <= '0;
                list_count_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr) begin
                // rebase: reload the cursor and empty every list
                cursor_reg <= cfg_data;
                total_reg  <= '0;
                for (int i = 0; i < NUM_CLASSES; i++) begin
                    list_head_reg[i]  <= '0;
                    list_tail_reg[i]  <= '0;
                    list_count_reg[i] <= '0;
                end
            end else begin
                cursor_reg <= cursor_next;
                total_reg  <= total_next;
                if (head_we) begin
                    list_head_reg[lst_wi] <= head_wd;
                end
                if (tail_we) begin
                    list_tail_reg[lst_wi] <= tail_wd;
                end
                if (cnt_we) begin
                    list_count_reg[lst_wi] <= cnt_wd;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        hdr_reg     <= hdr_next;
        out_res_reg <= out_res_next;
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        if (link_re) begin
            link_rd_q <= link_mem[link_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_mem[tag_wa] <= tag_wd;
        end
        if (tag_re) begin
            tag_rd_q <= tag_mem[tag_ra];
        end
    end

endmodule

/* rtl/size_class_block_allocator.sv */
// Top level of the size-class block allocator: ports, packing and checks.
//
// Usage:
//   Each command on the s_ channel (tuser = cmd: allocate or free) yields
//   exactly one result transfer on the m_ channel, in command order.
//   An allocate maps req_size to one of 18 size classes, reuses the head of
//   that class's free list if there is one, else bump-allocates an 8-byte
//   header plus the class size at the aligned cursor. A free appends the
//   block to the list of its recorded class.
//   A reject (bad size, null or foreign pointer) is answered when the back
//   end takes it from the queue; a reuse of a list's last block or a free
//   dropped at a full counter from the execute state; the rest from a pop,
//   bump or link state after it (registered link/tag memory reads first).
//   The back end works on one command at a time, taking one only when idle.
//   The cfg channel writes heap_base; it is always ready and must only be
//   written while no command is in flight. A write reloads the bump cursor
//   and empties every free list in the same cycle.
//   After reset heap_base is 0, the lists are empty and no clearing pass runs.
//   When the receiver stalls, the finished result holds in the output
//   register; the back end waits, the queue fills, then s_tready drops.
module size_class_block_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: heap_base write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // commands
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [28:0] req_size, [32:29] align_log2, [64:33] ptr_addr
    input  logic        s_tuser,   // [0] cmd
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] data_addr, [36:32] class_index, [37] reused
    output logic [1:0]  m_tuser    // [1:0] status
);
    import scba_pkg::*;

    logic         cfg_wr;
    scba_item_t   front_item;
    scba_heap_t   heap;
    logic         q_valid, q_ready;
    scba_item_t   q_data;
    scba_result_t res;

    // config always ready; the user keeps the block idle whenever written, unenforced
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    scba_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr     (cfg_wr),
        .cfg_data   (cfg_data),
        .cmd        (s_tuser),
        .req_size   (s_tdata[28:0]),
        .align_log2 (s_tdata[32:29]),
        .ptr_addr   (s_tdata[64:33]),
        .item       (front_item),
        .heap       (heap)
    );

    // queue decouples the classify step from list and memory updates
    scba_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_data  (front_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    scba_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_wr),
        .cfg_data  (cfg_data),
        .heap      (heap),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // pack the result transfer; upper tdata bits are zero fill
    assign m_tdata = {2'b00, res.reused, res.cls, res.data_addr};
    assign m_tuser = res.status;

`ifndef NO_ASSERTIONS
    // a failed command never returns an address or a reuse mark
    a_fail_no_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STAT_OK) |-> (m_tdata[31:0] == 32'd0 && !m_tdata[37]))
        else $error("failed result carries an address or reuse flag");

    // reuse only comes with a successful allocate
    a_reuse_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[37]) |-> (m_tuser == STAT_OK))
        else $error("reused result with non-ok status");

    // class index stays inside the class table
    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[36:32] < CLASS_W'(NUM_CLASSES)))
        else $error("class index out of range");
`endif

endmodule

/* test/scba_scoreboard_pkg.sv */
// Scoreboard for the size-class block allocator: command prediction and in-order result checks.
package scba_scoreboard_pkg;
    import scba_pkg::*;

    localparam int unsigned SLOT_COUNT = HEAP_BYTES / 8 + 1;

    class alloc_scoreboard;
        bit [31:0]        heap_base;
        bit [31:0]        cursor;
        int unsigned      free_total;
        int unsigned      head_slot[NUM_CLASSES];
        int unsigned      tail_slot[NUM_CLASSES];
        int unsigned      list_len[NUM_CLASSES];
        int unsigned      next_slot[SLOT_COUNT];
        bit [CLASS_W-1:0] slot_class[SLOT_COUNT];
        longint unsigned  class_span[NUM_CLASSES];
        scba_result_t     awaited[$];
        int unsigned      mismatches;
        int unsigned      results_seen;

        function new();
            class_span = '{8, 16, 24, 32, 64, 128, 256, 512, 1024, 2048, 4096, 8192,
                           1 << 15, 1 << 16, 1 << 18, 1 << 20, 1 << 23, 1 << 28};
            mismatches   = 0;
            results_seen = 0;
            heap_base    = '0;
            empty_lists();
            foreach (next_slot[i]) begin
                next_slot[i]  = 0;
                slot_class[i] = '0;
            end
        endfunction

        function void empty_lists();
            cursor     = heap_base;
            free_total = 0;
            foreach (head_slot[c]) begin
                head_slot[c] = 0;
                tail_slot[c] = 0;
                list_len[c]  = 0;
            end
        endfunction

        // a base write reloads the cursor and drops every list; tags survive
        function void rebase(bit [31:0] value);
            heap_base = value;
            empty_lists();
        endfunction

        function bit [63:0] window_limit();
            bit [63:0] lim;
            lim = {32'd0, heap_base} + 64'(HEAP_BYTES);
            return (lim > {32'd0, HEAP_TOP}) ? {32'd0, HEAP_TOP} : lim;
        endfunction

        function int unsigned slot_of(bit [63:0] hdr);
            bit [63:0] offs;
            offs = (hdr - {32'd0, heap_base[31:3], 3'b000}) >> 3;
            return (offs < SLOT_COUNT) ? offs[31:0] : SLOT_COUNT - 1;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        // predict the result of one accepted command and queue it
        function scba_result_t take_command(bit cmd, bit [SIZE_W-1:0] size,
                                            bit [3:0] align_log2, bit [31:0] ptr);
            scba_result_t r;
            bit [63:0]    lim;
            bit [63:0]    base_al;
            bit [63:0]    mask;
            bit [63:0]    hdr;
            bit [63:0]    block_end;
            bit [63:0]    ptr_w;
            int unsigned  cls;
            int unsigned  slot;
            int unsigned  align;
            r       = '0;
            lim     = window_limit();
            base_al = {32'd0, heap_base[31:3], 3'b000};
            ptr_w   = {32'd0, ptr};
            if (cmd == CMD_ALLOC) begin
                if (size == 0 || size > MAX_SIZE) begin
                    r.status = STAT_BAD_SIZE;
                end else begin
                    cls = 0;
                    while (cls < NUM_CLASSES - 1 && size > class_span[cls]) cls++;
                    if (free_total > 0 && list_len[cls] > 0) begin
                        slot = head_slot[cls];
                        if (list_len[cls] == 1) begin
                            head_slot[cls] = 0;
                            tail_slot[cls] = 0;
                        end else begin
                            head_slot[cls] = next_slot[slot];
                        end
                        list_len[cls]--;
                        free_total--;
                        r.data_addr = 32'(base_al + (64'(slot) << 3) + 64'd8);
                        r.cls       = CLASS_W'(cls);
                        r.reused    = 1'b1;
                    end else begin
                        align     = (align_log2 < MIN_ALIGN) ? MIN_ALIGN : align_log2;
                        mask      = (64'd1 << align) - 64'd1;
                        hdr       = ({32'd0, cursor} + mask) & ~mask;
                        block_end = hdr + 64'd8 + class_span[cls];
                        if (block_end > lim) begin
                            r.status = STAT_NO_SPACE;
                        end else begin
                            cursor           = block_end[31:0];
                            slot             = slot_of(hdr);
                            slot_class[slot] = CLASS_W'(cls);
                            r.data_addr      = 32'(hdr + 64'd8);
                            r.cls            = CLASS_W'(cls);
                        end
                    end
                end
            end else if (ptr != 0) begin
                if (ptr_w < {32'd0, heap_base} + 64'd8 || ptr_w >= lim) begin
                    r.status = STAT_FOREIGN;
                end else begin
                    slot = slot_of(ptr_w - 64'd8);
                    cls  = slot_class[slot];
                    if (cls >= NUM_CLASSES) cls = NUM_CLASSES - 1;
                    r.cls = CLASS_W'(cls);
                    // saturated counters drop the free but still report it
                    if (free_total < COUNT_MAX && list_len[cls] < COUNT_MAX) begin
                        if (list_len[cls] == 0) head_slot[cls] = slot;
                        else next_slot[tail_slot[cls]] = slot;
                        next_slot[slot] = 0;
                        tail_slot[cls]  = slot;
                        list_len[cls]++;
                        free_total++;
                    end
                end
            end
            awaited.push_back(r);
            return r;
        endfunction

        function void match_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            end
        endfunction

        function void check_result(logic [39:0] tdata, logic [1:0] tuser);
            scba_result_t want;
            results_seen++;
            if (awaited.size() == 0) begin
                mismatches++;
                $error("result with no command outstanding: data_addr 0x%0h status %0d",
                       tdata[31:0], tuser);
                return;
            end
            want = awaited.pop_front();
            match_field("data_addr", want.data_addr, tdata[31:0]);
            match_field("class_index", 32'(want.cls), 32'(tdata[36:32]));
            match_field("reused", 32'(want.reused), 32'(tdata[37]));
            match_field("status", 32'(want.status), 32'(tuser));
        endfunction
    endclass

endpackage

/* test/size_class_block_allocator_tb.sv */
// Top-level testbench of the size-class block allocator: stimulus, handshakes and final verdict.
module size_class_block_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scba_pkg::*;
    import scba_scoreboard_pkg::*;

    localparam int unsigned PERIOD        = 10;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned IDLE_PCT      = 36;
    localparam int unsigned PHASE_ITEMS   = 200;
    localparam int unsigned SETTLE_CYCLES = 16;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;    // [28:0] req_size, [32:29] align_log2, [64:33] ptr_addr
    logic        s_tuser   = 1'b0;  // [0] cmd
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;           // [31:0] data_addr, [36:32] class_index, [37] reused
    logic [1:0]  m_tuser;           // [1:0] status

    alloc_scoreboard board;
    scba_result_t    last_outcome;
    logic [31:0]     live_blocks[$];   // blocks handed out and not freed since
    logic [31:0]     born_blocks[$];   // every block bump-allocated under the current base
    logic            steady = 1'b0;    // suppress idling on both sides
    int unsigned     cycles = 0;
    int unsigned     alloc_count = 0;
    int unsigned     free_count = 0;
    int unsigned     base_writes = 0;

    logic [31:0] phase_bases[6] = '{32'h0000_0000, 32'h0001_0000, 32'h8000_0008,
                                    32'hFFFF_0000, 32'h0000_1003, 32'h7FFF_F000};

    size_class_block_allocator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #(PERIOD / 2) aclk = ~aclk;

    // Abort a hung run: count cycles and bail out well past the slowest correct run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: decide the stall for the coming edge at the falling edge.
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Check every result transfer against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tdata, m_tuser);
        end
    end

    // Present one command, hold it until the transfer, then predict its result.
    task automatic send_command(input logic cmd, input logic [SIZE_W-1:0] size,
                                input logic [3:0] align_log2, input logic [31:0] ptr);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, ptr, align_log2, size};
        do @(posedge aclk); while (!s_tready);
        last_outcome = board.take_command(cmd, size, align_log2, ptr);
        if (cmd == CMD_ALLOC) begin
            alloc_count++;
            if (last_outcome.status == STAT_OK) begin
                live_blocks.push_back(last_outcome.data_addr);
                if (!last_outcome.reused) born_blocks.push_back(last_outcome.data_addr);
            end
        end else begin
            free_count++;
            for (int i = 0; i < live_blocks.size(); i++) begin
                if (live_blocks[i] == ptr) begin
                    live_blocks.delete(i);
                    break;
                end
            end
        end
    endtask

    // Drop valid and hold off until every predicted result has been transferred.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write heap_base; the block is idle here, so lists and cursor restart at once.
    task automatic write_heap_base(input logic [31:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        board.rebase(value);
        live_blocks.delete();
        born_blocks.delete();
        base_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Pick an address the block must reject as outside the heap (or null when base is 0).
    function automatic logic [31:0] foreign_address();
        logic [63:0] lim;
        logic [63:0] low;
        logic [31:0] ptr;
        lim = board.window_limit();
        low = {32'd0, board.heap_base} + 64'd8;
        ptr = $urandom();
        if ({32'd0, ptr} >= low && {32'd0, ptr} < lim) begin
            if ($urandom_range(1) == 1 && lim <= 64'hFFFF_FFFF) ptr = lim[31:0];
            else ptr = board.heap_base + $urandom_range(7);
        end
        return ptr;
    endfunction

    // Allocate with sizes weighted toward the small classes; a few bad or huge ones.
    task automatic random_alloc();
        int unsigned       pick;
        logic [SIZE_W-1:0] size;
        logic [3:0]        align_log2;
        pick = $urandom_range(99);
        if (pick < 45)      size = SIZE_W'($urandom_range(64, 1));
        else if (pick < 70) size = SIZE_W'($urandom_range(1024, 65));
        else if (pick < 82) size = SIZE_W'($urandom_range(40000, 1025));
        else if (pick < 88) size = SIZE_W'(board.class_span[$urandom_range(NUM_CLASSES - 1)]);
        else if (pick < 94) size = SIZE_W'($urandom_range(MAX_SIZE, 1));
        else if (pick < 96) size = '0;
        else size = SIZE_W'($urandom_range((1 << 29) - 1, int'(MAX_SIZE) + 1));
        align_log2 = ($urandom_range(99) < 75) ? 4'($urandom_range(4)) : 4'($urandom_range(15));
        send_command(CMD_ALLOC, size, align_log2, $urandom());
    endtask

    // Free mostly live blocks; sometimes a double free, a null or a foreign pointer.
    task automatic random_free();
        int unsigned pick;
        logic [31:0] ptr;
        pick = $urandom_range(99);
        if (pick < 80 && live_blocks.size() != 0)
            ptr = live_blocks[$urandom_range(live_blocks.size() - 1)];
        else if (pick < 88 && born_blocks.size() != 0)
            ptr = born_blocks[$urandom_range(born_blocks.size() - 1)];
        else if (pick < 93)
            ptr = '0;
        else
            ptr = foreign_address();
        send_command(CMD_FREE, SIZE_W'($urandom()), 4'($urandom()), ptr);
    endtask

    initial begin
        logic [31:0] first_block;
        board = new();

        // Hold reset, then release it on a falling edge.
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes and the corner cases under the reset base of 0.
        send_command(CMD_ALLOC, 1, 0, 32'hFFFF_FFFF);        // smallest request
        first_block = last_outcome.data_addr;
        send_command(CMD_ALLOC, 0, 0, 0);                    // zero size
        send_command(CMD_ALLOC, MAX_SIZE + SIZE_W'(1), 4'd15, 0); // just past the largest class
        send_command(CMD_ALLOC, '1, 4'd15, '1);              // widest size field
        send_command(CMD_ALLOC, MAX_SIZE, 4'd15, 0);         // largest class, no room
        send_command(CMD_ALLOC, 24, 4'd12, 0);               // header on a 4 KiB boundary
        send_command(CMD_ALLOC, 32768, 0, 0);
        send_command(CMD_ALLOC, 32768, 0, 0);                // heap exhausted
        send_command(CMD_FREE, 0, 0, first_block);
        send_command(CMD_FREE, '1, '1, first_block);         // double free
        send_command(CMD_FREE, 0, 0, 0);                     // null pointer
        send_command(CMD_FREE, 0, 0, 32'hFFFF_FFFF);         // far past the heap
        send_command(CMD_FREE, 0, 0, HEAP_BYTES);            // exactly at the heap end
        send_command(CMD_FREE, 0, 0, 7);                     // below base plus header
        send_command(CMD_ALLOC, 5, 0, 0);                    // reuse from the list
        send_command(CMD_ALLOC, 8, 0, 0);                    // reuse the duplicate entry
        send_command(CMD_ALLOC, 9, 4'd3, 0);                 // next class, bump path
        drain();
        write_heap_base(32'hFFFF_FFFF);                      // heap end capped below base
        send_command(CMD_ALLOC, 8, 0, 0);
        send_command(CMD_FREE, 0, 0, 32'h1234_5678);
        drain();
        write_heap_base(32'hFFFF_FFF8);                      // empty heap at the cap
        send_command(CMD_ALLOC, 1, 0, 0);
        send_command(CMD_FREE, 0, 0, 32'hFFFF_FFFF);

        // Random phases, each under its own heap base; one phase runs without idling.
        foreach (phase_bases[p]) begin
            drain();
            write_heap_base(phase_bases[p]);
            steady = (p == 2);
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(99) < 55) random_alloc();
                else random_free();
            end
        end
        steady = 1'b0;

        // Wait out the last results, then report.
        drain();
        $display("Run covered %0d allocates and %0d frees under %0d heap base writes,",
                 alloc_count, free_count, base_writes);
        $display("with list reuse, double frees, exhaustion and foreign pointers; %0d results.",
                 board.results_seen);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/scba_pkg.sv
rtl/scba_front.sv
rtl/scba_queue.sv
rtl/scba_back.sv
rtl/size_class_block_allocator.sv
test/scba_scoreboard_pkg.sv
test/size_class_block_allocator_tb.sv
